FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// check that also holds while reset is low
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// types, constants and codes shared by the stereo spatial panner
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int DELAY_DEPTH = 64;
  localparam int IDX_W       = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

  localparam int SAMPLE_W = 16;
  localparam int SCALED_W = 17;
  localparam int GAIN_W   = 17;
  localparam int PAN_W    = 16;
  localparam int RATE_W   = 18;
  localparam int FILT_W   = 24;
  localparam int FGAIN_W  = 32;
  localparam int MEM_W    = 2 * SCALED_W;

  // shared multiplier operand and product widths
  localparam int A_W = 35;
  localparam int B_W = 25;
  localparam int P_W = A_W + B_W;

  localparam int UNITY_GAIN    = 65536;
  localparam int HALF_PAN      = 32768;
  localparam int ITD_COEF      = 2791729;
  localparam int BLEND_Q16     = 20972;
  localparam int FAR_SLOPE_Q16 = 29491;
  localparam int RND_SHIFT     = 47;

  localparam logic [FGAIN_W-1:0] FAR_UNITY = 32'h8000_0000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN        = 3'd0,
    CFG_PAN         = 3'd1,
    CFG_SPATIAL     = 3'd2,
    CFG_HEAD_MODEL  = 3'd3,
    CFG_SRC_MONO    = 3'd4,
    CFG_OUT_MONO    = 3'd5,
    CFG_SAMPLE_RATE = 3'd6
  } cfg_idx_e;

  // post-scaling applied to the registered product
  typedef enum logic [2:0] {
    MUL_SH0,
    MUL_SH16,
    MUL_SH17,
    MUL_SH31,
    MUL_SH38,
    MUL_RND47
  } mul_mode_e;

  typedef struct packed {
    mul_mode_e             mode;
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [MEM_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_MONO,
    S_P_L,
    S_P_R,
    S_L_TL,
    S_L_OL,
    S_L_TR,
    S_L_OR,
    S_H_SL,
    S_H_SR,
    S_H_P,
    S_H_D,
    S_H_G,
    S_H_RD,
    S_H_F,
    S_H_O,
    S_DONE
  } state_e;

endpackage

FILE: hw/rtl/ssp_mul.sv
// ----------------------------------------------------------------------------
// ssp_mul
// shared signed multiplier with registered product and scaling that
// truncates toward zero, or rounds half up for the delay length
// ----------------------------------------------------------------------------
module ssp_mul
  import ssp_pkg::*;
(
  input  logic                  clk_i,
  input  mul_req_t              req_i,
  output logic signed [A_W-1:0] result_o
);

  logic signed [P_W-1:0] prod_q;
  mul_mode_e             mode_q;
  logic [5:0]            sh;
  logic signed [P_W-1:0] bias;
  logic signed [P_W-1:0] shifted;

  always_ff @(posedge clk_i) begin
    prod_q <= P_W'(req_i.a) * P_W'(req_i.b);
    mode_q <= req_i.mode;
  end

  always_comb begin
    unique case (mode_q)
      MUL_SH0:   sh = 6'd0;
      MUL_SH16:  sh = 6'd16;
      MUL_SH17:  sh = 6'd17;
      MUL_SH31:  sh = 6'd31;
      MUL_SH38:  sh = 6'd38;
      MUL_RND47: sh = 6'(RND_SHIFT);
      default:   sh = 6'd0;
    endcase
    if (mode_q == MUL_RND47) begin
      bias = P_W'(1) <<< (RND_SHIFT - 1);
    end else if (prod_q[P_W-1]) begin
      // negative product: bias so the shift truncates toward zero
      bias = (P_W'(1) <<< sh) - P_W'(1);
    end else begin
      bias = '0;
    end
    shifted  = (prod_q + bias) >>> sh;
    result_o = shifted[A_W-1:0];
  end

endmodule

FILE: hw/rtl/ssp_delay_mem.sv
// ----------------------------------------------------------------------------
// ssp_delay_mem
// left and right delay lines in one memory word, registered read,
// per-entry valid bits so unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
module ssp_delay_mem
  import ssp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_req_t         req_i,
  output logic [MEM_W-1:0] rd_data_o
);

  logic [MEM_W-1:0]       mem [DELAY_DEPTH];
  logic [DELAY_DEPTH-1:0] valid_q;
  logic [MEM_W-1:0]       rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= valid_q[req_i.raddr] ? mem[req_i.raddr] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/stereo_spatial_panner.sv
// ----------------------------------------------------------------------------
// stereo_spatial_panner
// Takes one source frame (left and right sample) per input beat and returns
// one output frame per output beat; both channels use valid/ready.
// Configuration is a plain write port (enable, index, data); the user must write it only
// while the block is idle, which the block itself does not enforce; unknown indexes are ignored.
// A small sequencer drives one shared multiplier, one product per cycle.
// The sequencer hands over at once at zero gain; mono output scales the
// summed pair; no 3D scales left, then right; linear pan scales and weights
// each side; the head model scales both sides, derives the delay, stores
// the pair and, off center, forms the far gain, then filters and scales
// the delayed far-side sample. Input ready is low while an item is in work.
// A finished frame sits in the output register; the next input is taken
// meanwhile, and it waits in its last step only while that frame is still
// stalled by the receiver.
// Reset sets the configuration registers to their defaults, clears the filters and the
// write index, and marks every delay entry unwritten so it reads as zero;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module stereo_spatial_panner
  import ssp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] left_sample_i,
  input  logic signed [SAMPLE_W-1:0] right_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SCALED_W-1:0] left_out_o,
  output logic signed [SCALED_W-1:0] right_out_o
);

  // configuration registers
  logic [GAIN_W-1:0]       gain_q;
  logic signed [PAN_W-1:0] pan_q;
  logic                    spatial_q;
  logic                    head_model_q;
  logic                    src_mono_q;
  logic                    out_mono_q;
  logic [RATE_W-1:0]       rate_q;

  state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] xl_q, xl_d, xr_q, xr_d;
  logic signed [SCALED_W-1:0] lo_q, lo_d, ro_q, ro_d;
  logic signed [SCALED_W-1:0] left_q, left_d, right_q, right_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [FILT_W-1:0]   filt_l_q, filt_l_d, filt_r_q, filt_r_d;
  logic [IDX_W-1:0]           wi_q, wi_d, ri_q, ri_d;
  logic [FGAIN_W-1:0]         far_gain_q, far_gain_d;

  mul_req_t              mul_req;
  logic signed [A_W-1:0] mul_res;
  mem_req_t              mem_req;
  logic [MEM_W-1:0]      mem_rdata;

  logic [GAIN_W-1:0]          g_sat;
  logic [PAN_W-1:0]           apan;
  logic                       far_left;
  logic [GAIN_W-1:0]          lf, rf;
  logic signed [SCALED_W-1:0] mono_sum;
  logic signed [SCALED_W-1:0] delayed;
  logic signed [FILT_W-1:0]   f_sel;
  logic signed [FILT_W:0]     diff;
  logic signed [FILT_W-1:0]   f_new;
  logic [IDX_W-1:0]           d_cl;
  logic [IDX_W:0]             ri_full;

  ssp_mul u_mul (
    .clk_i    (clk_i),
    .req_i    (mul_req),
    .result_o (mul_res)
  );

  ssp_delay_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= GAIN_W'(UNITY_GAIN);
      pan_q        <= '0;
      spatial_q    <= 1'b0;
      head_model_q <= 1'b0;
      src_mono_q   <= 1'b0;
      out_mono_q   <= 1'b0;
      rate_q       <= RATE_W'(48000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GAIN:        gain_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_PAN:         pan_q        <= cfg_data_i[PAN_W-1:0];
        CFG_SPATIAL:     spatial_q    <= cfg_data_i[0];
        CFG_HEAD_MODEL:  head_model_q <= cfg_data_i[0];
        CFG_SRC_MONO:    src_mono_q   <= cfg_data_i[0];
        CFG_OUT_MONO:    out_mono_q   <= cfg_data_i[0];
        CFG_SAMPLE_RATE: rate_q       <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // gain above unity saturates
  assign g_sat    = (gain_q > GAIN_W'(UNITY_GAIN)) ? GAIN_W'(UNITY_GAIN) : gain_q;
  assign apan     = pan_q[PAN_W-1] ? PAN_W'(-pan_q) : PAN_W'(pan_q);
  assign far_left = !pan_q[PAN_W-1] && (pan_q != '0);
  assign lf       = far_left ? GAIN_W'(HALF_PAN) - GAIN_W'(apan) : GAIN_W'(HALF_PAN);
  assign rf       = pan_q[PAN_W-1] ? GAIN_W'(HALF_PAN) - GAIN_W'(apan)
                                   : GAIN_W'(HALF_PAN);
  assign mono_sum = SCALED_W'(xl_q) + SCALED_W'(xr_q);
  assign delayed  = far_left ? mem_rdata[MEM_W-1:SCALED_W] : mem_rdata[SCALED_W-1:0];
  assign f_sel    = far_left ? filt_l_q : filt_r_q;
  assign diff     = ((FILT_W+1)'(delayed) <<< 7) - (FILT_W+1)'(f_sel);
  assign f_new    = f_sel + mul_res[FILT_W-1:0];
  assign d_cl     = (mul_res > A_W'(DELAY_DEPTH - 1)) ? IDX_W'(DELAY_DEPTH - 1)
                                                      : mul_res[IDX_W-1:0];
  assign ri_full  = (wi_q >= d_cl) ? (IDX_W+1)'(wi_q) - (IDX_W+1)'(d_cl)
                                   : (IDX_W+1)'(wi_q) + (IDX_W+1)'(DELAY_DEPTH)
                                     - (IDX_W+1)'(d_cl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      filt_l_q    <= '0;
      filt_r_q    <= '0;
      wi_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      filt_l_q    <= filt_l_d;
      filt_r_q    <= filt_r_d;
      wi_q        <= wi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xl_q       <= xl_d;
    xr_q       <= xr_d;
    lo_q       <= lo_d;
    ro_q       <= ro_d;
    left_q     <= left_d;
    right_q    <= right_d;
    ri_q       <= ri_d;
    far_gain_q <= far_gain_d;
  end

  always_comb begin
    state_d     = state_q;
    xl_d        = xl_q;
    xr_d        = xr_q;
    lo_d        = lo_q;
    ro_d        = ro_q;
    left_d      = left_q;
    right_d     = right_q;
    out_valid_d = out_valid_q && !out_ready_i;
    filt_l_d    = filt_l_q;
    filt_r_d    = filt_r_q;
    wi_d        = wi_q;
    ri_d        = ri_q;
    far_gain_d  = far_gain_q;
    mul_req     = '{mode: MUL_SH0, a: '0, b: '0};
    mem_req     = '{we: 1'b0, waddr: wi_q, wdata: {lo_q, ro_q}, re: 1'b0, raddr: ri_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          xl_d    = left_sample_i;
          xr_d    = src_mono_q ? left_sample_i : right_sample_i;
          state_d = S_START;
        end
      end
      S_START: begin
        priority if (g_sat == '0) begin
          lo_d    = '0;
          ro_d    = '0;
          state_d = S_DONE;
        end else if (out_mono_q) begin
          mul_req = '{mode: MUL_SH17, a: A_W'(mono_sum), b: B_W'(g_sat)};
          state_d = S_MONO;
        end else if (spatial_q && head_model_q) begin
          mul_req = '{mode: MUL_SH16, a: A_W'(xl_q), b: B_W'(g_sat)};
          state_d = S_H_SL;
        end else if (spatial_q) begin
          mul_req = '{mode: MUL_SH0, a: A_W'(xl_q), b: B_W'(g_sat)};
          state_d = S_L_TL;
        end else begin
          mul_req = '{mode: MUL_SH16, a: A_W'(xl_q), b: B_W'(g_sat)};
          state_d = S_P_L;
        end
      end
      S_MONO: begin
        lo_d    = mul_res[SCALED_W-1:0];
        ro_d    = '0;
        state_d = S_DONE;
      end
      S_P_L: begin
        lo_d    = mul_res[SCALED_W-1:0];
        mul_req = '{mode: MUL_SH16, a: A_W'(xr_q), b: B_W'(g_sat)};
        state_d = S_P_R;
      end
      S_P_R: begin
        ro_d    = mul_res[SCALED_W-1:0];
        state_d = S_DONE;
      end
      S_L_TL: begin
        mul_req = '{mode: MUL_SH31, a: mul_res, b: B_W'(lf)};
        state_d = S_L_OL;
      end
      S_L_OL: begin
        lo_d    = mul_res[SCALED_W-1:0];
        mul_req = '{mode: MUL_SH0, a: A_W'(xr_q), b: B_W'(g_sat)};
        state_d = S_L_TR;
      end
      S_L_TR: begin
        mul_req = '{mode: MUL_SH31, a: mul_res, b: B_W'(rf)};
        state_d = S_L_OR;
      end
      S_L_OR: begin
        ro_d    = mul_res[SCALED_W-1:0];
        state_d = S_DONE;
      end
      S_H_SL: begin
        lo_d    = mul_res[SCALED_W-1:0];
        mul_req = '{mode: MUL_SH16, a: A_W'(xr_q), b: B_W'(g_sat)};
        state_d = S_H_SR;
      end
      S_H_SR: begin
        ro_d    = mul_res[SCALED_W-1:0];
        mul_req = '{mode: MUL_SH0, a: A_W'(rate_q), b: B_W'(apan)};
        state_d = S_H_P;
      end
      S_H_P: begin
        mul_req = '{mode: MUL_RND47, a: mul_res, b: B_W'(ITD_COEF)};
        state_d = S_H_D;
      end
      S_H_D: begin
        // store the scaled pair, then look back by the clamped delay
        mem_req.we = 1'b1;
        ri_d       = ri_full[IDX_W-1:0];
        wi_d       = (wi_q == IDX_W'(DELAY_DEPTH - 1)) ? '0 : wi_q + 1'b1;
        if (pan_q == '0) begin
          state_d = S_DONE;
        end else begin
          mul_req = '{mode: MUL_SH0, a: A_W'(apan), b: B_W'(FAR_SLOPE_Q16)};
          state_d = S_H_G;
        end
      end
      S_H_G: begin
        far_gain_d = FAR_UNITY - mul_res[FGAIN_W-1:0];
        mem_req.re = 1'b1;
        state_d    = S_H_RD;
      end
      S_H_RD: begin
        mul_req = '{mode: MUL_SH16, a: A_W'(diff), b: B_W'(BLEND_Q16)};
        state_d = S_H_F;
      end
      S_H_F: begin
        if (far_left) begin
          filt_l_d = f_new;
        end else begin
          filt_r_d = f_new;
        end
        mul_req = '{mode: MUL_SH38, a: A_W'(far_gain_q), b: B_W'(f_new)};
        state_d = S_H_O;
      end
      S_H_O: begin
        if (far_left) begin
          lo_d = mul_res[SCALED_W-1:0];
        end else begin
          ro_d = mul_res[SCALED_W-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          left_d      = lo_q;
          right_d     = ro_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

endmodule

FILE: hw/rtl/ssp_checker.sv
// ----------------------------------------------------------------------------
// ssp_checker
// port-level checks for the stereo spatial panner, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssp_checker
  import ssp_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [SCALED_W-1:0] left_out_o,
  input logic signed [SCALED_W-1:0] right_out_o
);

  logic out_stall;
  logic left_ok;
  logic right_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign left_ok   = (left_out_o >= -17'sd32768) && (left_out_o <= 17'sd32768);
  assign right_ok  = (right_out_o >= -17'sd32768) && (right_out_o <= 17'sd32768);

  // one frame in work at a time
  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(left_out_o))

  `ASSERT_CLK(a_out_hold_r, clk_i, rst_ni, out_stall |=> $stable(right_out_o))

  // outputs never leave the range -32768 to 32768
  `ASSERT_CLK(a_out_range, clk_i, rst_ni, out_valid_o |-> left_ok && right_ok)

  // reset is asynchronous; check the cycle after it is seen low
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o && in_ready_o)

endmodule

bind stereo_spatial_panner ssp_checker u_ssp_checker (.*);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// stereo spatial panner testbench
// Drives source frames through the panner under many register settings. A
// scoreboard predicts every output frame (gain, mono mixing, linear pan, and
// the head model with interaural delay and far-ear low-pass) and compares
// each output beat with the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import ssp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int FRAME_COUNT = 1300;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    logic signed [SCALED_W-1:0] left;
    logic signed [SCALED_W-1:0] right;
  } out_frame_t;

  class frame_scoreboard;
    logic [GAIN_W-1:0]        gain;
    logic signed [PAN_W-1:0]  pan;
    bit                       spatial;
    bit                       head_model;
    bit                       src_mono;
    bit                       out_mono;
    logic [RATE_W-1:0]        rate;
    int                       left_line [DELAY_DEPTH];
    int                       right_line [DELAY_DEPTH];
    int                       wr_idx;
    int                       left_shadow;
    int                       right_shadow;
    out_frame_t               expected_frames [$];
    int                       errors;

    function new();
      gain         = UNITY_GAIN;
      pan          = '0;
      spatial      = 1'b0;
      head_model   = 1'b0;
      src_mono     = 1'b0;
      out_mono     = 1'b0;
      rate         = 48000;
      wr_idx       = 0;
      left_shadow  = 0;
      right_shadow = 0;
      errors       = 0;
      foreach (left_line[i]) begin
        left_line[i]  = 0;
        right_line[i] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN:        gain = data[GAIN_W-1:0];
        CFG_PAN:         pan = data[PAN_W-1:0];
        CFG_SPATIAL:     spatial = data[0];
        CFG_HEAD_MODEL:  head_model = data[0];
        CFG_SRC_MONO:    src_mono = data[0];
        CFG_OUT_MONO:    out_mono = data[0];
        CFG_SAMPLE_RATE: rate = data[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    // one-pole low-pass toward the delayed sample, 7 fraction bits
    function void shadow_step(inout int filt, input int delayed);
      longint diff;
      diff = longint'(delayed) * 128 - longint'(filt);
      filt = filt + int'((diff * BLEND_Q16) / 65536);
    endfunction

    function void take_frame(logic signed [SAMPLE_W-1:0] l_smp,
                             logic signed [SAMPLE_W-1:0] r_smp);
      longint xl, xr, g, lo, ro, sl, sr, far_g, lf, rf;
      longint unsigned apan, dly;
      int wi, ri;
      out_frame_t want;
      xl = l_smp;
      xr = src_mono ? xl : longint'(r_smp);
      g  = (gain > UNITY_GAIN) ? longint'(UNITY_GAIN) : longint'(gain);
      lo = 0;
      ro = 0;
      if (g == 0) begin
        lo = 0;
        ro = 0;
      end else if (out_mono) begin
        lo = ((xl + xr) * g) / 131072;
        ro = 0;
      end else if (spatial && head_model) begin
        sl    = (xl * g) / 65536;
        sr    = (xr * g) / 65536;
        apan  = (pan < 0) ? -longint'(pan) : longint'(pan);
        dly   = (apan * rate * ITD_COEF + (64'd1 << 46)) >> RND_SHIFT;
        far_g = (longint'(1) << 31) - longint'(FAR_SLOPE_Q16) * longint'(apan);
        if (dly > DELAY_DEPTH - 1) dly = DELAY_DEPTH - 1;
        wi = wr_idx;
        left_line[wi]  = int'(sl);
        right_line[wi] = int'(sr);
        ri = (wi + DELAY_DEPTH - int'(dly)) % DELAY_DEPTH;
        lo = sl;
        ro = sr;
        if (pan > 0) begin
          shadow_step(left_shadow, left_line[ri]);
          lo = (longint'(left_shadow) * far_g) / (longint'(1) << 38);
        end else if (pan < 0) begin
          shadow_step(right_shadow, right_line[ri]);
          ro = (longint'(right_shadow) * far_g) / (longint'(1) << 38);
        end
        wr_idx = (wi + 1) % DELAY_DEPTH;
      end else if (spatial) begin
        lf = (pan > 0) ? HALF_PAN - longint'(pan) : longint'(HALF_PAN);
        rf = (pan < 0) ? HALF_PAN + longint'(pan) : longint'(HALF_PAN);
        lo = (xl * g * lf) / (longint'(1) << 31);
        ro = (xr * g * rf) / (longint'(1) << 31);
      end else begin
        lo = (xl * g) / 65536;
        ro = (xr * g) / 65536;
      end
      want.left  = lo[SCALED_W-1:0];
      want.right = ro[SCALED_W-1:0];
      expected_frames = {expected_frames, want};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("mismatch: %s", msg);
    endtask

    task check_frame(logic signed [SCALED_W-1:0] l_out, logic signed [SCALED_W-1:0] r_out);
      out_frame_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("output beat %0d/%0d with nothing expected", l_out, r_out));
        return;
      end
      want = expected_frames.pop_front();
      if (l_out !== want.left)
        report($sformatf("left_out %0d, expected %0d", l_out, want.left));
      if (r_out !== want.right)
        report($sformatf("right_out %0d, expected %0d", r_out, want.right));
    endtask

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] left_sample_i = '0;
  logic signed [SAMPLE_W-1:0] right_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SCALED_W-1:0] left_out_o;
  logic signed [SCALED_W-1:0] right_out_o;

  frame_scoreboard board;
  int              tx_quiet = 0;
  int              rx_quiet = 0;
  bit              hold_out_req = 1'b0;
  int              frames_sent = 0;

  stereo_spatial_panner uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.take_frame(left_sample_i, right_sample_i);
      if (out_valid_o && out_ready_i) board.check_frame(left_out_o, right_out_o);
    end
  end

  // idle cycles before a beat, with occasional stretches of none
  task automatic draw_gap(inout int quiet, output int gap);
    if (quiet > 0) begin
      quiet--;
      gap = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [31:0] v;
    v = value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v[CFG_DATA_W-1:0];
    board.write_reg(idx, v[CFG_DATA_W-1:0]);
  endtask

  task automatic cfg_close();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l_smp,
                            input logic signed [SAMPLE_W-1:0] r_smp);
    int gap;
    draw_gap(tx_quiet, gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    left_sample_i  <= l_smp;
    right_sample_i <= r_smp;
    do @(posedge clk_i); while (!in_ready_o);
    frames_sent++;
  endtask

  // stop offering and wait for every predicted frame to come out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return $signed(v[3:0]);
      default: return v[SAMPLE_W-1:0];
    endcase
  endfunction

  task automatic random_settings();
    int g, p, r;
    case ($urandom_range(0, 7))
      0:       g = 0;
      1:       g = UNITY_GAIN;
      2:       g = $urandom_range(UNITY_GAIN + 1, 131071);
      3:       g = 1;
      default: g = $urandom_range(1, UNITY_GAIN);
    endcase
    case ($urandom_range(0, 7))
      0:       p = -32768;
      1:       p = 32767;
      2:       p = 0;
      3:       p = $urandom_range(0, 200) - 100;
      default: p = $urandom_range(0, 65535) - 32768;
    endcase
    case ($urandom_range(0, 7))
      0:       r = 8000;
      1:       r = 48000;
      2:       r = 192000;
      3:       r = ($urandom_range(0, 1) != 0) ? 0 : 262143;
      4:       r = 44100;
      default: r = $urandom_range(8000, 192000);
    endcase
    cfg_write(CFG_GAIN, g);
    cfg_write(CFG_PAN, p);
    cfg_write(CFG_SPATIAL, ($urandom_range(0, 9) < 8) ? 1 : 0);
    cfg_write(CFG_HEAD_MODEL, ($urandom_range(0, 9) < 7) ? 1 : 0);
    cfg_write(CFG_SRC_MONO, ($urandom_range(0, 9) < 3) ? 1 : 0);
    cfg_write(CFG_OUT_MONO, ($urandom_range(0, 9) < 2) ? 1 : 0);
    cfg_write(CFG_SAMPLE_RATE, r);
    if ($urandom_range(0, 7) == 0) cfg_write(CFG_UNUSED, $urandom_range(0, 262143));
    cfg_close();
  endtask

  // receiver: random ready gaps, plus one long hold-off on request
  initial begin : receiver
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_out_req) begin
        stall = LONG_HOLD;
        hold_out_req = 1'b0;
      end else begin
        draw_gap(rx_quiet, stall);
      end
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    int n_frames;
    int phase_no;
    int settle;
    board = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: plain stereo at unity gain
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(-16'sd1, 16'sd1);

    // gain above unity saturates; mono source copies left
    drain();
    cfg_write(CFG_GAIN, 131071);
    cfg_write(CFG_SRC_MONO, 1);
    cfg_close();
    send_frame(16'sh8000, 16'sd5);
    send_frame(16'sh7fff, 16'sd0);

    // zero gain silences everything and holds the state
    drain();
    cfg_write(CFG_GAIN, 0);
    cfg_write(CFG_SPATIAL, 1);
    cfg_write(CFG_HEAD_MODEL, 1);
    cfg_write(CFG_PAN, 32767);
    cfg_close();
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);

    // mono output ignores 3D settings
    drain();
    cfg_write(CFG_GAIN, UNITY_GAIN);
    cfg_write(CFG_SRC_MONO, 0);
    cfg_write(CFG_OUT_MONO, 1);
    cfg_close();
    send_frame(16'sh7fff, 16'sh7fff);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);

    // head model at center pan: lines written, filters untouched
    drain();
    cfg_write(CFG_OUT_MONO, 0);
    cfg_write(CFG_PAN, 0);
    cfg_close();
    send_frame(16'sd1000, -16'sd1000);
    send_frame(16'sh8000, 16'sh7fff);

    // hard right at the top rate: delay clamps to the line depth minus one
    drain();
    cfg_write(CFG_PAN, 32767);
    cfg_write(CFG_SAMPLE_RATE, 192000);
    cfg_close();
    repeat (3) send_frame(rand_sample(), rand_sample());

    // hard left at the lowest rate
    drain();
    cfg_write(CFG_PAN, -32768);
    cfg_write(CFG_SAMPLE_RATE, 8000);
    cfg_close();
    repeat (3) send_frame(rand_sample(), rand_sample());

    // zero rate gives no delay; unknown index must be ignored
    drain();
    cfg_write(CFG_SAMPLE_RATE, 0);
    cfg_write(CFG_PAN, -1);
    cfg_write(CFG_UNUSED, 262143);
    cfg_close();
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);

    // linear pan at both extremes
    drain();
    cfg_write(CFG_HEAD_MODEL, 0);
    cfg_write(CFG_PAN, -32768);
    cfg_close();
    send_frame(16'sh7fff, 16'sh8000);
    drain();
    cfg_write(CFG_PAN, 32767);
    cfg_close();
    send_frame(16'sh8000, 16'sh7fff);

    // smallest nonzero gain
    drain();
    cfg_write(CFG_SPATIAL, 0);
    cfg_write(CFG_GAIN, 1);
    cfg_close();
    send_frame(16'sh8000, 16'sh7fff);

    phase_no = 0;
    while (frames_sent < FRAME_COUNT) begin
      drain();
      random_settings();
      if (phase_no == 3) begin
        hold_out_req = 1'b1;
        n_frames = 60;
      end else begin
        n_frames = $urandom_range(10, 90);
      end
      repeat (n_frames) send_frame(rand_sample(), rand_sample());
      phase_no++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    settle = 0;
    while (board.pending() > 0 && settle < 5000) begin
      @(posedge clk_i);
      settle++;
    end
    if (board.pending() > 0)
      board.report($sformatf("%0d frames never came out", board.pending()));
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("stereo_spatial_panner regression: pass");
    end else begin
      $display("stereo_spatial_panner regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("stereo_spatial_panner regression: fail");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_mul.sv
hw/rtl/ssp_delay_mem.sv
hw/rtl/stereo_spatial_panner.sv
hw/rtl/ssp_checker.sv
test/tb.sv
